### rtl/core/jsr_oau_pkg.sv
// ----------------------------------------------------------------------------
// JSR operand address unit package
// Shared field widths, transaction codes and address arithmetic constants.
// ----------------------------------------------------------------------------
package jsr_oau_pkg;

  localparam int DATA_W = 16;
  localparam int REG_W  = 3;
  localparam int MODE_W = 3;
  localparam int KIND_W = 3;

  localparam logic [DATA_W-1:0] WORD_STEP = 16'd2;
  localparam logic [DATA_W-1:0] EVEN_MASK = 16'hFFFE;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_DECODE = 2'd1,
    OP_REPLY  = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_REGVAL = 3'd0,
    KIND_REGLOC = 3'd1,
    KIND_MEMLOC = 3'd2,
    KIND_RDREQ  = 3'd3,
    KIND_BUSERR = 3'd4,
    KIND_SEQERR = 3'd5
  } kind_t;

  localparam logic [MODE_W-1:0] MODE_REG         = 3'd0;
  localparam logic [MODE_W-1:0] MODE_REG_DEF     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_AUTOINC     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_AUTOINC_DEF = 3'd3;
  localparam logic [MODE_W-1:0] MODE_AUTODEC     = 3'd4;
  localparam logic [MODE_W-1:0] MODE_AUTODEC_DEF = 3'd5;
  localparam logic [MODE_W-1:0] MODE_INDEX       = 3'd6;
  localparam logic [MODE_W-1:0] MODE_INDEX_DEF   = 3'd7;

endpackage

### rtl/core/jsr_oau_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered (read-first).
// ----------------------------------------------------------------------------
module jsr_oau_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/jsr_oau_seq.sv
// ----------------------------------------------------------------------------
// JSR operand address sequencer
// Read-modify-write control around the register file RAM, addressing phase
// tracking and the registered result stage.
// ----------------------------------------------------------------------------
module jsr_oau_seq
  import jsr_oau_pkg::*;
#(
  parameter int NUM_REGISTERS = 8,
  parameter int AW            = $clog2(NUM_REGISTERS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_op,
  input  logic [REG_W-1:0]  in_register_select,
  input  logic [MODE_W-1:0] in_addressing_mode,
  input  logic [REG_W-1:0]  in_linkage_register,
  input  logic [DATA_W-1:0] in_data,
  input  logic              in_bus_error,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [KIND_W-1:0] out_kind,
  output logic [REG_W-1:0]  out_register_number,
  output logic [DATA_W-1:0] out_value,
  output logic [REG_W-1:0]  out_linkage_out,
  output logic              ram_we,
  output logic [AW-1:0]     ram_waddr,
  output logic [DATA_W-1:0] ram_wdata,
  output logic [AW-1:0]     ram_raddr,
  input  logic [DATA_W-1:0] ram_rdata
);

  localparam logic [AW-1:0] PC_IDX = AW'(NUM_REGISTERS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RMW,
    S_IDX,
    S_SUM,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_POINTER,
    PH_INDEX,
    PH_DEFER
  } phase_t;

  state_t              state_r,     state_nxt;
  phase_t              phase_r,     phase_nxt;
  logic [MODE_W-1:0]   pend_mode_r, pend_mode_nxt;
  logic [AW-1:0]       pend_reg_r,  pend_reg_nxt;
  logic [REG_W-1:0]    pend_link_r, pend_link_nxt;
  logic [NUM_REGISTERS-1:0] valid_r, valid_nxt;
  logic                rd_valid_r;

  op_t                 op_r,        op_nxt;
  logic [AW-1:0]       sel_r,       sel_nxt;
  logic [DATA_W-1:0]   data_r,      data_nxt;
  logic                berr_r,      berr_nxt;
  logic [DATA_W-1:0]   r7p_r,       r7p_nxt;
  kind_t               kind_r,      kind_nxt;
  logic [REG_W-1:0]    regno_r,     regno_nxt;
  logic [DATA_W-1:0]   value_r,     value_nxt;

  logic [DATA_W-1:0]   rword;
  logic [DATA_W-1:0]   dec_word;
  logic [DATA_W-1:0]   base;
  logic [DATA_W-1:0]   sum;
  logic [AW-1:0]       in_sel;

  assign in_sel   = in_register_select[AW-1:0];
  // entries never written read as zero
  assign rword    = rd_valid_r ? ram_rdata : '0;
  assign dec_word = rword - WORD_STEP;
  assign base     = (pend_reg_r == PC_IDX) ? r7p_r : rword;
  assign sum      = base + data_r;

  assign in_ready            = (state_r == S_IDLE);
  assign out_valid           = (state_r == S_OUT);
  assign out_kind            = kind_r;
  assign out_register_number = regno_r;
  assign out_value           = value_r;
  assign out_linkage_out     = pend_link_r;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    pend_mode_nxt = pend_mode_r;
    pend_reg_nxt  = pend_reg_r;
    pend_link_nxt = pend_link_r;
    valid_nxt     = valid_r;
    op_nxt        = op_r;
    sel_nxt       = sel_r;
    data_nxt      = data_r;
    berr_nxt      = berr_r;
    r7p_nxt       = r7p_r;
    kind_nxt      = kind_r;
    regno_nxt     = regno_r;
    value_nxt     = value_r;
    ram_we        = 1'b0;
    ram_waddr     = sel_r;
    ram_wdata     = rword;
    ram_raddr     = sel_r;

    case (state_r)
      S_IDLE: begin
        ram_raddr = in_sel;
        if (in_valid) begin
          op_nxt    = op_t'(in_op);
          sel_nxt   = in_sel;
          data_nxt  = in_data;
          berr_nxt  = in_bus_error;
          regno_nxt = '0;
          value_nxt = '0;
          state_nxt = S_OUT;
          case (op_t'(in_op))
            OP_WRITE: begin
              ram_we            = 1'b1;
              ram_waddr         = in_sel;
              ram_wdata         = in_data;
              valid_nxt[in_sel] = 1'b1;
              kind_nxt          = KIND_REGVAL;
              regno_nxt         = REG_W'(in_sel);
              value_nxt         = in_data;
            end
            OP_READ: begin
              state_nxt = S_RMW;
            end
            OP_DECODE: begin
              if (phase_r != PH_IDLE) begin
                kind_nxt = KIND_SEQERR;
              end else begin
                pend_mode_nxt = in_addressing_mode;
                pend_reg_nxt  = in_sel;
                pend_link_nxt = in_linkage_register;
                if (in_addressing_mode == MODE_REG) begin
                  kind_nxt  = KIND_REGLOC;
                  regno_nxt = REG_W'(in_sel);
                end else begin
                  state_nxt = S_RMW;
                  if (in_addressing_mode inside {MODE_INDEX, MODE_INDEX_DEF}) begin
                    ram_raddr = PC_IDX;
                  end
                end
              end
            end
            OP_REPLY: begin
              case (phase_r)
                PH_IDLE: begin
                  kind_nxt = KIND_SEQERR;
                end
                PH_INDEX: begin
                  ram_raddr = PC_IDX;
                  state_nxt = S_IDX;
                end
                default: begin
                  phase_nxt = PH_IDLE;
                  kind_nxt  = in_bus_error ? KIND_BUSERR : KIND_MEMLOC;
                  value_nxt = in_bus_error ? '0 : in_data;
                end
              endcase
            end
            default: begin
              kind_nxt = KIND_SEQERR;
            end
          endcase
        end
      end

      S_RMW: begin
        state_nxt = S_OUT;
        if (op_r == OP_READ) begin
          kind_nxt  = KIND_REGVAL;
          regno_nxt = REG_W'(sel_r);
          value_nxt = rword;
        end else begin
          case (pend_mode_r)
            MODE_REG_DEF: begin
              kind_nxt  = KIND_MEMLOC;
              value_nxt = rword;
            end
            MODE_AUTOINC, MODE_AUTOINC_DEF: begin
              ram_we           = 1'b1;
              ram_wdata        = (rword + WORD_STEP) & EVEN_MASK;
              valid_nxt[sel_r] = 1'b1;
              value_nxt        = rword;
              if (pend_mode_r == MODE_AUTOINC) begin
                kind_nxt = KIND_MEMLOC;
              end else begin
                kind_nxt  = KIND_RDREQ;
                phase_nxt = PH_POINTER;
              end
            end
            MODE_AUTODEC, MODE_AUTODEC_DEF: begin
              ram_we           = 1'b1;
              ram_wdata        = dec_word & EVEN_MASK;
              valid_nxt[sel_r] = 1'b1;
              value_nxt        = dec_word;
              if (pend_mode_r == MODE_AUTODEC) begin
                kind_nxt = KIND_MEMLOC;
              end else begin
                kind_nxt  = KIND_RDREQ;
                phase_nxt = PH_POINTER;
              end
            end
            default: begin
              kind_nxt  = KIND_RDREQ;
              value_nxt = rword;
              phase_nxt = PH_INDEX;
            end
          endcase
        end
      end

      S_IDX: begin
        // R7 advances even when the index fetch failed
        ram_we            = 1'b1;
        ram_waddr         = PC_IDX;
        ram_wdata         = rword + WORD_STEP;
        valid_nxt[PC_IDX] = 1'b1;
        r7p_nxt           = rword + WORD_STEP;
        ram_raddr         = pend_reg_r;
        if (berr_r) begin
          phase_nxt = PH_IDLE;
          kind_nxt  = KIND_BUSERR;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_SUM;
        end
      end

      S_SUM: begin
        // read of R7 above was issued alongside its write: forward
        value_nxt = sum;
        state_nxt = S_OUT;
        if (pend_mode_r == MODE_INDEX) begin
          kind_nxt  = KIND_MEMLOC;
          phase_nxt = PH_IDLE;
        end else begin
          kind_nxt  = KIND_RDREQ;
          phase_nxt = PH_DEFER;
        end
      end

      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    sel_r      <= sel_nxt;
    data_r     <= data_nxt;
    berr_r     <= berr_nxt;
    r7p_r      <= r7p_nxt;
    kind_r     <= kind_nxt;
    regno_r    <= regno_nxt;
    value_r    <= value_nxt;
    rd_valid_r <= valid_r[ram_raddr];
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_IDLE;
      pend_mode_r <= '0;
      pend_reg_r  <= '0;
      pend_link_r <= '0;
      valid_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      pend_mode_r <= pend_mode_nxt;
      pend_reg_r  <= pend_reg_nxt;
      pend_link_r <= pend_link_nxt;
      valid_r     <= valid_nxt;
    end
  end

endmodule

### rtl/core/jsr_operand_address_unit.sv
// ----------------------------------------------------------------------------
// JSR operand address unit
// Effective address generation for the PDP-11 style addressing modes of a
// jump-to-subroutine operand, register file held in a one-read, one-write RAM.
// ----------------------------------------------------------------------------
// Path: writes, sequence errors, register locations and pointer/deferred
//   replies go straight to S_OUT; register reads, decodes and failed index
//   replies pass S_RMW or S_IDX first; an index reply passes S_IDX and S_SUM
//   (R7 read, R7 write with base read, add). Flow: one transaction in flight;
//   the next is accepted in the cycle after the result transaction.
// Reset: synchronous; unwritten registers read as zero via per-entry valid bits.
module jsr_operand_address_unit
  import jsr_oau_pkg::*;
#(
  parameter int NUM_REGISTERS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_op,
  input  logic [REG_W-1:0]  in_register_select,
  input  logic [MODE_W-1:0] in_addressing_mode,
  input  logic [REG_W-1:0]  in_linkage_register,
  input  logic [DATA_W-1:0] in_data,
  input  logic              in_bus_error,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [KIND_W-1:0] out_kind,
  output logic [REG_W-1:0]  out_register_number,
  output logic [DATA_W-1:0] out_value,
  output logic [REG_W-1:0]  out_linkage_out
);

  localparam int AW = $clog2(NUM_REGISTERS);

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  jsr_oau_ram #(
    .WIDTH (DATA_W),
    .DEPTH (NUM_REGISTERS)
  ) u_regfile (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  jsr_oau_seq #(
    .NUM_REGISTERS (NUM_REGISTERS)
  ) u_seq (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_op               (in_op),
    .in_register_select  (in_register_select),
    .in_addressing_mode  (in_addressing_mode),
    .in_linkage_register (in_linkage_register),
    .in_data             (in_data),
    .in_bus_error        (in_bus_error),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_kind            (out_kind),
    .out_register_number (out_register_number),
    .out_value           (out_value),
    .out_linkage_out     (out_linkage_out),
    .ram_we              (ram_we),
    .ram_waddr           (ram_waddr),
    .ram_wdata           (ram_wdata),
    .ram_raddr           (ram_raddr),
    .ram_rdata           (ram_rdata)
  );

endmodule

### rtl/core/jsr_oau_checker.sv
// ----------------------------------------------------------------------------
// JSR operand address unit checker
// Port-level properties of the transaction flow and result encoding.
// ----------------------------------------------------------------------------
module jsr_oau_assertions
  import jsr_oau_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [KIND_W-1:0] out_kind,
  input logic [REG_W-1:0]  out_register_number,
  input logic [DATA_W-1:0] out_value,
  input logic [REG_W-1:0]  out_linkage_out
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_value)
      && $stable(out_register_number) && $stable(out_linkage_out))
    else $error("result changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken before result");

  a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while result waits");

  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_BUSERR || out_kind == KIND_SEQERR
      || out_kind == KIND_REGLOC) |-> out_value == '0)
    else $error("fault or register location carries a value");

  a_addr_regno: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_MEMLOC || out_kind == KIND_RDREQ)
      |-> out_register_number == '0)
    else $error("address result carries a register number");

endmodule

bind jsr_operand_address_unit jsr_oau_assertions u_chk (.*);
